/* hw/rtl/vtps_pkg.sv */
package vtps_pkg;

  // Default logical pixel count of one active line.
  localparam int unsigned PIXELS_PER_LINE_DEF = 256;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 12;

  // Register reset values.
  localparam logic [1:0]  PATTERN_MODE_RST     = 2'd0;
  localparam logic [1:0]  VIDEO_STANDARD_RST   = 2'd0;
  localparam logic [11:0] SAMPLES_PER_LINE_RST = 12'd768;
  localparam logic [9:0]  ACTIVE_LINES_RST     = 10'd240;
  localparam logic [9:0]  RAMP_LINES_RST       = 10'd32;

  // Signal levels.
  localparam logic [15:0] LEVEL_BLACK = 16'd6400;
  localparam logic [15:0] LEVEL_WHITE = 16'd18176;

  // 11776 * r / 255 is split as 46 * r + 46 * r / 255.
  localparam logic [5:0]  RAMP_STEP    = 6'd46;
  // Reciprocal of 255, exact for numerators below 2^14.
  localparam logic [14:0] DIV255_MUL   = 15'd16449;
  localparam int unsigned DIV255_SHIFT = 22;
  // Reciprocal of 3, exact for numerators below 2^11.
  localparam logic [9:0]  DIV3_MUL     = 10'd683;
  localparam int unsigned DIV3_SHIFT   = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_MODE     = 3'd0,
    REG_VIDEO_STANDARD   = 3'd1,
    REG_SAMPLES_PER_LINE = 3'd2,
    REG_ACTIVE_LINES     = 3'd3,
    REG_RAMP_LINES       = 3'd4
  } vtps_reg_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_LUMA  = 2'd1,
    MODE_COLOR = 2'd2
  } vtps_mode_e;

  typedef enum logic [1:0] {
    STD_NTSC  = 2'd0,
    STD_PAL   = 2'd1,
    STD_PAL_M = 2'd2,
    STD_PAL_N = 2'd3
  } vtps_std_e;

  // Per-item context carried through the divider stages.
  typedef struct packed {
    logic        wr_ok;
    logic        lnum_odd;
    logic [9:0]  aline;
    logic [11:0] pos;
  } vtps_ctx_t;

  // Per-item decisions carried through the back-end stages.
  typedef struct packed {
    logic wr_ok;
    logic lnum_odd;
    logic in_ramp;
    logic marker;
  } vtps_flags_t;

  function automatic logic [15:0] luma_level(input logic [2:0] bar);
    logic [15:0] lvl;
    case (bar)
      3'd0:    lvl = 16'd18176;
      3'd1:    lvl = 16'd16880;
      3'd2:    lvl = 16'd14643;
      3'd3:    lvl = 16'd13348;
      3'd4:    lvl = 16'd11228;
      3'd5:    lvl = 16'd9933;
      3'd6:    lvl = 16'd7695;
      default: lvl = 16'd6400;
    endcase
    return lvl;
  endfunction

  function automatic logic [31:0] pal_ntsc_word(input logic [2:0] bar);
    logic [31:0] w;
    case (bar)
      3'd0:    w = 32'h49494949;
      3'd1:    w = 32'h454c413a;
      3'd2:    w = 32'h44323042;
      3'd3:    w = 32'h40352834;
      3'd4:    w = 32'h202b382c;
      3'd5:    w = 32'h1c2e301e;
      3'd6:    w = 32'h1b141f26;
      default: w = 32'h18181818;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pal_even_word(input logic [2:0] bar);
    logic [31:0] w;
    case (bar)
      3'd0:    w = 32'h49494949;
      3'd1:    w = 32'h47514035;
      3'd2:    w = 32'h27364e3f;
      3'd3:    w = 32'h243e452c;
      3'd4:    w = 32'h3d231c35;
      3'd5:    w = 32'h3a2b1322;
      3'd6:    w = 32'h1a10212c;
      default: w = 32'h18181818;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] pal_odd_word(input logic [2:0] bar);
    logic [31:0] w;
    case (bar)
      3'd0:    w = 32'h49494949;
      3'd1:    w = 32'h40514735;
      3'd2:    w = 32'h4e36273f;
      3'd3:    w = 32'h453e242c;
      3'd4:    w = 32'h1c233d35;
      3'd5:    w = 32'h132b3a22;
      3'd6:    w = 32'h21101a2c;
      default: w = 32'h18181818;
    endcase
    return w;
  endfunction

  // NTSC has a single palette; the PAL family swaps palettes line by line.
  function automatic logic [31:0] palette_word(input logic ntsc, input logic odd,
                                               input logic [2:0] bar);
    logic [31:0] w;
    if (ntsc) begin
      w = pal_ntsc_word(bar);
    end else if (odd) begin
      w = pal_odd_word(bar);
    end else begin
      w = pal_even_word(bar);
    end
    return w;
  endfunction

  // Five-pixel rows of the N and P standard marker glyphs.
  function automatic logic [4:0] glyph_row(input logic ntsc, input logic [2:0] row);
    logic [4:0] g;
    if (ntsc) begin
      case (row)
        3'd0:    g = 5'h11;
        3'd1:    g = 5'h19;
        3'd2:    g = 5'h15;
        3'd3:    g = 5'h13;
        3'd4:    g = 5'h11;
        3'd5:    g = 5'h11;
        3'd6:    g = 5'h11;
        default: g = 5'h00;
      endcase
    end else begin
      case (row)
        3'd0:    g = 5'h1e;
        3'd1:    g = 5'h11;
        3'd2:    g = 5'h11;
        3'd3:    g = 5'h1e;
        3'd4:    g = 5'h10;
        3'd5:    g = 5'h10;
        3'd6:    g = 5'h10;
        default: g = 5'h00;
      endcase
    end
    return g;
  endfunction

endpackage

/* hw/rtl/video_test_pattern_sampler.sv */
// Test pattern sampler: each input transfer names one sample of an active video line, and
// the matching output transfer carries the 16-bit level a color-bar, luma-bar or grey-ramp
// test pattern puts there, together with a written flag (0 means leave the sample alone,
// and the level then reads 0). One transfer is accepted per clock cycle when the output
// side keeps up. An accepted sample passes through $clog2(PIXELS_PER_LINE) + 5 register
// stages (13 at the default of 256 pixels): an input register, the sample-to-pixel
// divider, which resolves one quotient bit per pipeline stage, and four stages of bar,
// ramp, palette and marker logic, the last of which is the output register. Every
// stage has its own valid bit, so empty stages fill while the output is stalled.
// Registers are written through the plain write port and must only change while no
// transfer is in flight.
module video_test_pattern_sampler #(
  parameter int unsigned PIXELS_PER_LINE = vtps_pkg::PIXELS_PER_LINE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [vtps_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [vtps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_active_i,
  input  logic [9:0]                        line_number_i,
  input  logic [9:0]                        active_line_i,
  input  logic [11:0]                       sample_position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [15:0]                       sample_level_o,
  output logic                              written_o
);
  import vtps_pkg::*;

  // Geometry of the logical pixel grid.
  localparam int unsigned W      = PIXELS_PER_LINE;
  localparam int unsigned PXW    = $clog2(W);
  localparam int unsigned PW     = 12 + $clog2(W + 1);
  localparam int unsigned MARGIN = W / 10;
  localparam int unsigned SPAN3  = 3 * W;

  // Pipeline stage numbering: stage 0 registers the input, stages 1..PXW divide,
  // then four back-end stages, the last being the output register.
  localparam int unsigned SE1 = PXW + 1;
  localparam int unsigned SE2 = PXW + 2;
  localparam int unsigned SE3 = PXW + 3;
  localparam int unsigned SE4 = PXW + 4;
  localparam int unsigned NS  = PXW + 5;

  // Bar index pixel*8/W as a multiply by a rounded-up reciprocal.
  localparam int unsigned KB   = 23;
  localparam int unsigned MULB = ((1 << KB) + W - 1) / W;
  localparam int unsigned MBW  = $clog2(MULB + 1);
  localparam int unsigned BPW  = PXW + 3 + MBW;

  // Ramp value pixel*255/(W-1), same technique.
  localparam int unsigned KR   = 28;
  localparam int unsigned MULR = ((1 << KR) + W - 2) / (W - 1);
  localparam int unsigned MRW  = $clog2(MULR + 1);
  localparam int unsigned RNW  = PXW + 8;
  localparam int unsigned RPW  = RNW + MRW;

  // Configuration registers.
  logic [1:0]  pattern_mode_q;
  logic [1:0]  video_standard_q;
  logic [11:0] spl_q;
  logic [9:0]  active_lines_q;
  logic [9:0]  ramp_lines_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_mode_q   <= PATTERN_MODE_RST;
      video_standard_q <= VIDEO_STANDARD_RST;
      spl_q            <= SAMPLES_PER_LINE_RST;
      active_lines_q   <= ACTIVE_LINES_RST;
      ramp_lines_q     <= RAMP_LINES_RST;
    end else if (cfg_we_i) begin
      case (vtps_reg_e'(cfg_index_i))
        REG_PATTERN_MODE:     pattern_mode_q   <= cfg_data_i[1:0];
        REG_VIDEO_STANDARD:   video_standard_q <= cfg_data_i[1:0];
        REG_SAMPLES_PER_LINE: spl_q            <= cfg_data_i[11:0];
        REG_ACTIVE_LINES:     active_lines_q   <= cfg_data_i[9:0];
        REG_RAMP_LINES:       ramp_lines_q     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Flow control. A stage loads when it is empty or when the stage after it loads,
  // so bubbles are squeezed out even while the output register waits.
  logic [NS-1:0] v_q;
  logic [NS:0]   ld;

  always_comb begin
    ld[NS] = out_ready_i;
    for (int k = int'(NS) - 1; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < int'(NS); k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[NS-1];

  // Stage 0 and the restoring divider: pixel = position * W / samples_per_line.
  // The quotient is known to stay below 2^PXW, so the divider starts at that bit.
  logic             s0_ok;
  logic [PW-1:0]    dr_q   [PXW];
  logic [PXW-1:0]   dq_q   [PXW+1];
  vtps_ctx_t        dctx_q [PXW+1];
  logic [PW-1:0]    dr_n   [1:PXW];
  logic [PXW-1:0]   dq_n   [1:PXW];

  assign s0_ok = (pattern_mode_q != MODE_OFF) && in_active_i && (spl_q != '0) &&
                 (sample_position_i < spl_q);

  always_comb begin : div_comb
    logic [PW-1:0] dsr;
    logic          ge;
    for (int t = 1; t <= int'(PXW); t++) begin
      dsr     = PW'(spl_q) << (int'(PXW) - t);
      ge      = dr_q[t-1] >= dsr;
      dq_n[t] = dq_q[t-1] | (ge ? (PXW'(1) << (int'(PXW) - t)) : '0);
      dr_n[t] = ge ? (dr_q[t-1] - dsr) : dr_q[t-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      dr_q[0]   <= PW'(sample_position_i) * PW'(W);
      dq_q[0]   <= '0;
      dctx_q[0] <= '{wr_ok: s0_ok, lnum_odd: line_number_i[0], aline: active_line_i,
                     pos: sample_position_i};
    end
    for (int t = 1; t <= int'(PXW); t++) begin
      if (ld[t]) begin
        dq_q[t]   <= dq_n[t];
        dctx_q[t] <= dctx_q[t-1];
      end
    end
    // The last stage needs no remainder.
    for (int t = 1; t < int'(PXW); t++) begin
      if (ld[t]) begin
        dr_q[t] <= dr_n[t];
      end
    end
  end

  // Stage E1: pixel clamp, reciprocal products for bar and ramp, quad index of the
  // color samples, ramp-region test and the standard marker glyph.
  vtps_ctx_t        c1;
  logic [PXW-1:0]   px;
  logic [PXW-1:0]   pm8;
  logic [9:0]       ramp_first_line;
  logic [RNW-1:0]   nr;
  logic [RPW-1:0]   rprod;
  logic [BPW-1:0]   bprod;
  logic [19:0]      qp;
  logic [4:0]       glyph;
  logic [2:0]       mk_col;
  logic             mk_bit;
  logic             mk_hit;

  always_comb begin
    c1  = dctx_q[PXW];
    px  = ({1'b0, dq_q[PXW]} >= (PXW+1)'(W)) ? PXW'(W - 1) : dq_q[PXW];
    ramp_first_line = (active_lines_q > ramp_lines_q) ? (active_lines_q - ramp_lines_q) : '0;
    nr    = (RNW'(px) << 8) - RNW'(px);
    rprod = RPW'(nr) * RPW'(MULR);
    bprod = BPW'({px, 3'b000}) * BPW'(MULB);
    qp    = 20'(c1.pos[11:2]) * 20'(DIV3_MUL);
    // The glyph is drawn 2x: two lines per glyph row, two pixels per glyph column.
    glyph  = glyph_row(video_standard_q == STD_NTSC, c1.aline[3:1]);
    pm8    = px - PXW'(8);
    mk_col = pm8[3:1];
    mk_bit = (mk_col <= 3'd4) ? glyph[3'd4 - mk_col] : 1'b0;
    mk_hit = (c1.aline < 10'd14) && (px >= PXW'(8)) && (px < PXW'(18)) && mk_bit;
  end

  logic [7:0]   e1_ramp_q;
  logic         e1_lo_q;
  logic         e1_hi_q;
  logic [2:0]   e1_bar_q;
  logic [8:0]   e1_q12_q;
  logic [11:0]  e1_pos_q;
  vtps_flags_t  e1_flags_q;

  always_ff @(posedge clk_i) begin
    if (ld[SE1]) begin
      e1_ramp_q  <= rprod[KR+7:KR];
      e1_lo_q    <= px < PXW'(MARGIN);
      e1_hi_q    <= px >= PXW'(W - MARGIN);
      e1_bar_q   <= bprod[KB+2:KB];
      e1_q12_q   <= qp[DIV3_SHIFT+8:DIV3_SHIFT];
      e1_pos_q   <= c1.pos;
      e1_flags_q <= '{wr_ok: c1.wr_ok, lnum_odd: c1.lnum_odd,
                      in_ramp: c1.aline >= ramp_first_line, marker: mk_hit};
    end
  end

  // Stage E2: margin overrides, first part of the ramp level, and the color pixel
  // 4*quad + sample/3 of the current sample within its quad of twelve.
  logic [7:0]   ramp;
  logic [2:0]   bar;
  logic [13:0]  x46;
  logic [11:0]  t12;
  logic [11:0]  jv;
  logic [3:0]   j;
  logic [1:0]   jd;
  logic [10:0]  cpx;
  logic         span_ok;
  logic         col_ok;

  always_comb begin
    ramp = e1_lo_q ? 8'd0 : (e1_hi_q ? 8'd255 : e1_ramp_q);
    bar  = (e1_lo_q || e1_hi_q) ? 3'd7 : e1_bar_q;
    x46  = 14'(ramp) * 14'(RAMP_STEP);
    t12  = 12'({e1_q12_q, 3'b000}) + 12'({e1_q12_q, 2'b00});
    jv   = e1_pos_q - t12;
    j    = jv[3:0];
    if (j >= 4'd9) begin
      jd = 2'd3;
    end else if (j >= 4'd6) begin
      jd = 2'd2;
    end else if (j >= 4'd3) begin
      jd = 2'd1;
    end else begin
      jd = 2'd0;
    end
    cpx     = 11'({e1_q12_q, 2'b00}) + 11'(jd);
    span_ok = ({1'b0, spl_q} >= 13'(SPAN3)) && ({1'b0, e1_pos_q} < 13'(SPAN3));
    col_ok  = span_ok && (cpx < 11'(W));
  end

  logic [13:0]    e2_x46_q;
  logic [2:0]     e2_bar_q;
  logic [PXW-1:0] e2_cpx_q;
  logic           e2_col_ok_q;
  logic [1:0]     e2_bsel_q;
  vtps_flags_t    e2_flags_q;

  always_ff @(posedge clk_i) begin
    if (ld[SE2]) begin
      e2_x46_q    <= x46;
      e2_bar_q    <= bar;
      e2_cpx_q    <= cpx[PXW-1:0];
      e2_col_ok_q <= col_ok;
      // The byte lane is the sample index mod 4, which equals position mod 4.
      e2_bsel_q   <= e1_pos_q[1:0];
      e2_flags_q  <= e1_flags_q;
    end
  end

  // Stage E3: remainder of the ramp scaling, luma lookup, bar of the color pixel.
  logic [28:0]    rf;
  logic [BPW-1:0] cbprod;
  logic           cm;

  always_comb begin
    rf     = 29'(e2_x46_q) * 29'(DIV255_MUL);
    cbprod = BPW'({e2_cpx_q, 3'b000}) * BPW'(MULB);
    cm     = (e2_cpx_q < PXW'(MARGIN)) || (e2_cpx_q >= PXW'(W - MARGIN));
  end

  logic [5:0]   e3_rfrac_q;
  logic [13:0]  e3_x46_q;
  logic [15:0]  e3_luma_q;
  logic [2:0]   e3_cbar_q;
  logic         e3_cm_q;
  logic         e3_col_ok_q;
  logic [1:0]   e3_bsel_q;
  vtps_flags_t  e3_flags_q;

  always_ff @(posedge clk_i) begin
    if (ld[SE3]) begin
      e3_rfrac_q  <= rf[DIV255_SHIFT+5:DIV255_SHIFT];
      e3_x46_q    <= e2_x46_q;
      e3_luma_q   <= luma_level(e2_bar_q);
      e3_cbar_q   <= cbprod[KB+2:KB];
      e3_cm_q     <= cm;
      e3_col_ok_q <= e2_col_ok_q;
      e3_bsel_q   <= e2_bsel_q;
      e3_flags_q  <= e2_flags_q;
    end
  end

  // Stage E4: palette byte, final priority (ramp, then bars, then the marker on top).
  logic [2:0]   cbar;
  logic [31:0]  pword;
  logic [7:0]   cbyte;
  logic [15:0]  ramp_lvl;
  logic [15:0]  lvl;
  logic         wr;

  always_comb begin
    cbar     = e3_cm_q ? 3'd7 : e3_cbar_q;
    pword    = palette_word(video_standard_q == STD_NTSC, e3_flags_q.lnum_odd, cbar);
    cbyte    = 8'(pword >> {e3_bsel_q, 3'b000});
    ramp_lvl = LEVEL_BLACK + 16'(e3_x46_q) + 16'(e3_rfrac_q);
    lvl      = '0;
    wr       = 1'b0;
    if (e3_flags_q.in_ramp) begin
      lvl = ramp_lvl;
      wr  = 1'b1;
    end else if (pattern_mode_q == MODE_LUMA) begin
      lvl = e3_luma_q;
      wr  = 1'b1;
    end else if (e3_col_ok_q) begin
      lvl = {cbyte, 8'h00};
      wr  = 1'b1;
    end
    if (e3_flags_q.marker) begin
      lvl = LEVEL_WHITE;
      wr  = 1'b1;
    end
    // Samples outside the active, enabled part of the line are never touched.
    if (!e3_flags_q.wr_ok) begin
      lvl = '0;
      wr  = 1'b0;
    end
  end

  logic [15:0] sample_level_q;
  logic        written_q;

  always_ff @(posedge clk_i) begin
    if (ld[SE4]) begin
      sample_level_q <= lvl;
      written_q      <= wr;
    end
  end

  assign sample_level_o = sample_level_q;
  assign written_o      = written_q;

`ifndef SYNTHESIS
  // An untouched sample always reports a zero level.
  a_unwritten_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !written_o |-> sample_level_o == '0)
    else $error("unwritten sample carries a nonzero level");

  // A full pipeline with a stalled output must refuse new input.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while the pipeline is full and stalled");

  // An accepted input always occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted input lost at the first stage");
`endif

endmodule
